FILE: src/mek_pkg.sv
// shared types, constants and register indexes for the multi-event key detector
package mek_pkg;

   localparam int NUM_KEYS_DEF = 4;

   localparam int ACTION_W = 1;
   localparam int LEVEL_W = 4;
   localparam int LEVEL_IW = $clog2(LEVEL_W);
   localparam int KEY_IDX_W = 4;
   localparam int FLAG_W = 7;
   localparam int TIMER_W = 16;
   localparam int DIV_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // flag bit positions
   localparam int FLAG_HOLD = 0;
   localparam int FLAG_DOWN = 1;
   localparam int FLAG_UP = 2;
   localparam int FLAG_SINGLE = 3;
   localparam int FLAG_DOUBLE = 4;
   localparam int FLAG_LONG = 5;
   localparam int FLAG_REPEAT = 6;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_TICK = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_CHECK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_DIVIDER = 2'd3;

   localparam logic [TIMER_W-1:0] DOUBLE_WINDOW_RST = 16'd200;
   localparam logic [TIMER_W-1:0] LONG_TIME_RST = 16'd2000;
   localparam logic [TIMER_W-1:0] REPEAT_INTERVAL_RST = 16'd100;
   localparam logic [DIV_W-1:0] SAMPLE_DIVIDER_RST = 8'd20;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PRESSED = 3'd1,
      PH_WAIT_SECOND = 3'd2,
      PH_SECOND_HELD = 3'd3,
      PH_LONG_REPEAT = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN = 2'd1,
      ST_DONE = 2'd2
   } seq_state_type;

   typedef struct packed {
      logic level;
      phase_type phase;
      logic [TIMER_W-1:0] timer;
      logic [FLAG_W-1:0] flags;
   } entry_type;

   typedef struct packed {
      logic [TIMER_W-1:0] double_window;
      logic [TIMER_W-1:0] long_time;
      logic [TIMER_W-1:0] repeat_interval;
      logic [DIV_W-1:0] sample_divider;
   } cfg_type;

endpackage

FILE: src/mek_req_if.sv
// request channel interface of the key detector
interface mek_req_if;
   logic valid;
   logic ready;
   logic [mek_pkg::ACTION_W-1:0] action;
   logic [mek_pkg::LEVEL_W-1:0] key_levels;
   logic [mek_pkg::KEY_IDX_W-1:0] key_index;
   logic [mek_pkg::FLAG_W-1:0] flag_mask;

   modport source (output valid, output action, output key_levels, output key_index,
      output flag_mask, input ready);
   modport sink (input valid, input action, input key_levels, input key_index,
      input flag_mask, output ready);
endinterface

FILE: src/mek_rsp_if.sv
// response channel interface of the key detector
interface mek_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [mek_pkg::FLAG_W-1:0] flags_before;

   modport source (output valid, output hit, output flags_before, input ready);
   modport sink (input valid, input hit, input flags_before, output ready);
endinterface

FILE: src/multi_event_key_detector.sv
// Multi-event key detector: tracks NUM_KEYS keys, each with a press/release machine
// kept in a one-port-read, one-port-write state memory, and raises hold, down, up,
// single, double, long and repeat flags that a check request reads and clears. A tick
// request walks the memory one key per cycle (read, then update and write back); a
// check request touches one entry, or none when its key index is out of range. A new
// request is accepted only once the response of the last one has been loaded into the
// response register. Every request gives one response; a tick response carries zeros.
module multi_event_key_detector #(
   parameter int NUM_KEYS = mek_pkg::NUM_KEYS_DEF
) (
   input  logic clock,
   input  logic reset,
   mek_req_if.sink req_bus,
   mek_rsp_if.source rsp_bus,
   input  logic csr_wr_en,
   input  logic [mek_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mek_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int IDX_CMP_W = mek_pkg::KEY_IDX_W + 1;

   mek_pkg::seq_state_type state_ff, state_in;
   mek_pkg::cfg_type cfg_ff;

   logic [mek_pkg::ACTION_W-1:0] action_ff;
   logic [mek_pkg::LEVEL_W-1:0] levels_ff;
   logic [mek_pkg::FLAG_W-1:0] mask_ff;
   logic sample_ff, sample_in;
   logic [mek_pkg::DIV_W-1:0] presc_ff, presc_in;
   logic [KEY_AW-1:0] key_ff, key_in;
   logic issue_ff, issue_in;
   logic pend_ff, pend_in;
   logic [KEY_AW-1:0] pend_key_ff;
   logic res_hit_ff, res_hit_in;
   logic [mek_pkg::FLAG_W-1:0] res_flags_ff, res_flags_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff;
   logic [mek_pkg::FLAG_W-1:0] rsp_flags_ff;

   logic req_take;
   logic is_tick;
   logic in_range;
   logic [mek_pkg::DIV_W-1:0] presc_inc;
   logic slot_free;
   logic rsp_load;
   logic [IDX_CMP_W-1:0] pend_key_x;
   logic level_now;

   mek_pkg::entry_type rd_data;
   mek_pkg::entry_type wr_data;
   logic upd_hit;
   logic [mek_pkg::FLAG_W-1:0] upd_flags;
   logic rd_en;
   logic wr_en;

   assign req_bus.ready = (state_ff == mek_pkg::ST_IDLE);
   assign req_take = req_bus.valid & req_bus.ready;
   assign is_tick = (action_ff == mek_pkg::ACT_TICK);
   assign in_range = IDX_CMP_W'(req_bus.key_index) < IDX_CMP_W'(NUM_KEYS);
   assign presc_inc = presc_ff + mek_pkg::DIV_W'(1);
   assign slot_free = ~rsp_valid_ff | rsp_bus.ready;
   assign rd_en = (state_ff == mek_pkg::ST_RUN) & issue_ff;
   assign wr_en = (state_ff == mek_pkg::ST_RUN) & pend_ff;

   // keys past the level field always read unpressed
   assign pend_key_x = IDX_CMP_W'(pend_key_ff);
   assign level_now = (pend_key_x < IDX_CMP_W'(mek_pkg::LEVEL_W)) ?
      levels_ff[pend_key_x[mek_pkg::LEVEL_IW-1:0]] : 1'b0;

   mek_store #(
      .NUM_KEYS(NUM_KEYS),
      .KEY_AW(KEY_AW)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .rd_en(rd_en),
      .rd_addr(key_ff),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(pend_key_ff),
      .wr_data(wr_data)
   );

   mek_key_update u_update (
      .entry_rd(rd_data),
      .is_tick(is_tick),
      .sample(sample_ff),
      .level_now(level_now),
      .cfg(cfg_ff),
      .mask(mask_ff),
      .entry_wr(wr_data),
      .hit(upd_hit),
      .flags_before(upd_flags)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mek_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_bus.action == mek_pkg::ACT_CHECK && !in_range) begin
                  state_in = mek_pkg::ST_DONE;
               end else begin
                  state_in = mek_pkg::ST_RUN;
               end
            end
         end
         mek_pkg::ST_RUN: begin
            if (pend_ff && !issue_ff) begin
               state_in = mek_pkg::ST_DONE;
            end
         end
         mek_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = mek_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mek_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      presc_in = presc_ff;
      sample_in = sample_ff;
      key_in = key_ff;
      issue_in = issue_ff;
      pend_in = 1'b0;
      res_hit_in = res_hit_ff;
      res_flags_in = res_flags_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         mek_pkg::ST_IDLE: begin
            if (req_take) begin
               res_hit_in = 1'b0;
               res_flags_in = '0;
               issue_in = 1'b1;
               if (req_bus.action == mek_pkg::ACT_TICK) begin
                  key_in = '0;
                  if (presc_inc >= cfg_ff.sample_divider) begin
                     presc_in = '0;
                     sample_in = 1'b1;
                  end else begin
                     presc_in = presc_inc;
                     sample_in = 1'b0;
                  end
               end else begin
                  key_in = req_bus.key_index[KEY_AW-1:0];
                  sample_in = 1'b0;
               end
            end
         end
         mek_pkg::ST_RUN: begin
            pend_in = issue_ff;
            if (issue_ff) begin
               if (is_tick && key_ff != KEY_AW'(NUM_KEYS - 1)) begin
                  key_in = key_ff + KEY_AW'(1);
               end else begin
                  issue_in = 1'b0;
               end
            end
            if (pend_ff && !is_tick) begin
               res_hit_in = upd_hit;
               res_flags_in = upd_flags;
            end
         end
         mek_pkg::ST_DONE: begin
            issue_in = 1'b0;
            rsp_load = slot_free;
         end
         default: begin
            issue_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mek_pkg::ST_IDLE;
         presc_ff <= '0;
         sample_ff <= 1'b0;
         issue_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_ff <= '0;
         pend_key_ff <= '0;
      end else begin
         state_ff <= state_in;
         presc_ff <= presc_in;
         sample_ff <= sample_in;
         issue_ff <= issue_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff <= key_in;
         pend_key_ff <= key_ff;
      end
   end

   // request payload and result holding
   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff <= req_bus.action;
         levels_ff <= req_bus.key_levels;
         mask_ff <= req_bus.flag_mask;
      end
      res_hit_ff <= res_hit_in;
      res_flags_ff <= res_flags_in;
      if (rsp_load) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_flags_ff <= res_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_window <= mek_pkg::DOUBLE_WINDOW_RST;
         cfg_ff.long_time <= mek_pkg::LONG_TIME_RST;
         cfg_ff.repeat_interval <= mek_pkg::REPEAT_INTERVAL_RST;
         cfg_ff.sample_divider <= mek_pkg::SAMPLE_DIVIDER_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mek_pkg::REG_DOUBLE_WINDOW: cfg_ff.double_window <= csr_wdata;
            mek_pkg::REG_LONG_TIME: cfg_ff.long_time <= csr_wdata;
            mek_pkg::REG_REPEAT_INTERVAL: cfg_ff.repeat_interval <= csr_wdata;
            mek_pkg::REG_SAMPLE_DIVIDER: begin
               cfg_ff.sample_divider <= csr_wdata[mek_pkg::DIV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.hit = rsp_hit_ff;
   assign rsp_bus.flags_before = rsp_flags_ff;

`ifndef NO_ASSERTIONS
   // the walk never reads the entry being written back
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && key_ff == pend_key_ff))
      else $error("read and write of the same key entry in one cycle");

   // a new request is only taken once all write-backs are done
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!pend_ff && !issue_ff))
      else $error("request accepted with memory work outstanding");

   // an out-of-range check skips the memory
   a_range_skip: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_bus.action == mek_pkg::ACT_CHECK && !in_range)
      |=> (state_ff == mek_pkg::ST_DONE && !res_hit_ff && res_flags_ff == '0))
      else $error("out-of-range check did not finish with a zero result");

   // the walk always ends by moving on to the done state
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mek_pkg::ST_RUN && pend_ff && !issue_ff) |=> state_ff == mek_pkg::ST_DONE)
      else $error("memory walk did not hand over to response");
`endif

endmodule

FILE: src/mek_store.sv
// per-key state memory with registered read and per-entry valid bits
module mek_store #(
   parameter int NUM_KEYS = mek_pkg::NUM_KEYS_DEF,
   parameter int KEY_AW = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic rd_en,
   input  logic [KEY_AW-1:0] rd_addr,
   output mek_pkg::entry_type rd_data,
   input  logic wr_en,
   input  logic [KEY_AW-1:0] wr_addr,
   input  mek_pkg::entry_type wr_data
);

   mek_pkg::entry_type mem [NUM_KEYS];
   logic [NUM_KEYS-1:0] valid_ff;
   mek_pkg::entry_type rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as the reset state
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: src/mek_key_update.sv
// read-modify-write logic for one key entry: timer, sampling machine and flag clear
module mek_key_update (
   input  mek_pkg::entry_type entry_rd,
   input  logic is_tick,
   input  logic sample,
   input  logic level_now,
   input  mek_pkg::cfg_type cfg,
   input  logic [mek_pkg::FLAG_W-1:0] mask,
   output mek_pkg::entry_type entry_wr,
   output logic hit,
   output logic [mek_pkg::FLAG_W-1:0] flags_before
);

   logic prev_level;
   logic rose;
   logic fell;

   assign prev_level = entry_rd.level;
   assign rose = level_now & ~prev_level;
   assign fell = ~level_now & prev_level;
   assign flags_before = entry_rd.flags;

   always_comb begin
      entry_wr = entry_rd;
      hit = 1'b0;
      if (is_tick) begin
         if (entry_rd.timer != '0) begin
            entry_wr.timer = entry_rd.timer - mek_pkg::TIMER_W'(1);
         end
         if (sample) begin
            entry_wr.level = level_now;
            entry_wr.flags[mek_pkg::FLAG_HOLD] = level_now;
            unique case (entry_rd.phase)
               mek_pkg::PH_IDLE: begin
                  if (rose) begin
                     entry_wr.flags[mek_pkg::FLAG_DOWN] = 1'b1;
                     entry_wr.timer = cfg.long_time;
                     entry_wr.phase = mek_pkg::PH_PRESSED;
                  end
               end
               mek_pkg::PH_PRESSED: begin
                  if (fell) begin
                     entry_wr.flags[mek_pkg::FLAG_UP] = 1'b1;
                     entry_wr.timer = cfg.double_window;
                     entry_wr.phase = mek_pkg::PH_WAIT_SECOND;
                  end else if (entry_wr.timer == '0) begin
                     entry_wr.flags[mek_pkg::FLAG_LONG] = 1'b1;
                     entry_wr.timer = cfg.repeat_interval;
                     entry_wr.phase = mek_pkg::PH_LONG_REPEAT;
                  end
               end
               mek_pkg::PH_WAIT_SECOND: begin
                  if (rose) begin
                     entry_wr.flags[mek_pkg::FLAG_DOUBLE] = 1'b1;
                     entry_wr.phase = mek_pkg::PH_SECOND_HELD;
                  end else if (entry_wr.timer == '0) begin
                     entry_wr.flags[mek_pkg::FLAG_SINGLE] = 1'b1;
                     entry_wr.phase = mek_pkg::PH_IDLE;
                  end
               end
               mek_pkg::PH_SECOND_HELD: begin
                  if (fell) begin
                     entry_wr.phase = mek_pkg::PH_IDLE;
                  end
               end
               mek_pkg::PH_LONG_REPEAT: begin
                  if (fell) begin
                     entry_wr.phase = mek_pkg::PH_IDLE;
                  end else if (entry_wr.timer == '0) begin
                     entry_wr.flags[mek_pkg::FLAG_REPEAT] = 1'b1;
                     entry_wr.timer = cfg.repeat_interval;
                  end
               end
               default: begin
                  // unused phase codes hold
               end
            endcase
         end
      end else begin
         hit = |(entry_rd.flags & mask);
         entry_wr.flags = entry_rd.flags & ~mask;
      end
   end

endmodule
